// ===== hdl/psps_pkg.sv =====
`timescale 1ns / 1ps
package psps_pkg;

    localparam logic [47:0] LOST_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] LOST_MIN = 48'h8000_0000_0000;
    localparam logic [47:0] SUM48_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] MSQ_MAX = 32'd4294836225;
    localparam logic [15:0] WINDOW_RESET = 16'd100;

    localparam logic [1:0] DIV_SEL_SIZE = 2'd0;
    localparam logic [1:0] DIV_SEL_SQUARE = 2'd1;
    localparam logic [1:0] DIV_SEL_RATE = 2'd2;
    localparam logic [1:0] DIV_SEL_MEAN = 2'd3;

    localparam logic [0:0] ADDR_OVERHEAD = 1'b0;
    localparam logic [0:0] ADDR_WINDOW = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic       load_item;
        logic       update;
        logic       div_start;
        logic [1:0] div_sel;
        logic       div_store;
        logic       out_load;
    } psps_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic is_media;
    } psps_stat_t;

endpackage

// ===== hdl/psps_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module psps_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic [63:0] quo,
    output logic        done
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, q_reg[63]} - {1'b0, den_reg};
        if (start)
        begin
            rem_next  = '0;
            q_next    = num;
            den_next  = den;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                q_next   = {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[62:0], q_reg[63]};
                q_next   = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    // zero divisor reads as a zero quotient
    assign quo  = (den_reg == 64'd0) ? 64'd0 : q_reg;
    assign done = done_reg;

endmodule

// ===== hdl/psps_ctrl.sv =====
`timescale 1ns / 1ps
module psps_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ok,
    output logic                 in_stall,
    input  logic                 out_stall,
    output logic                 out_valid,
    input  psps_pkg::psps_stat_t stat,
    output psps_pkg::psps_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_UPDATE, S_DIV_START, S_DIV_WAIT, S_OUT
    } state_t;

    state_t     state_reg;
    logic [1:0] sel_reg;
    logic       ovalid_reg;
    logic       accept;

    assign in_stall  = (state_reg != S_IDLE) || (ovalid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_valid = ovalid_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.load_item = accept;
        cmd.update    = (state_reg == S_UPDATE);
        cmd.div_start = (state_reg == S_DIV_START);
        cmd.div_sel   = sel_reg;
        cmd.div_store = (state_reg == S_DIV_WAIT) && stat.div_done;
        cmd.out_load  = (state_reg == S_OUT) && !(ovalid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            sel_reg    <= psps_pkg::DIV_SEL_SIZE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
                ovalid_reg <= 1'b1;
            else if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (accept && in_ok)
                        state_reg <= S_UPDATE;
                S_UPDATE:
                begin
                    sel_reg   <= psps_pkg::DIV_SEL_SIZE;
                    state_reg <= S_DIV_START;
                end
                S_DIV_START:
                    state_reg <= S_DIV_WAIT;
                S_DIV_WAIT:
                    if (stat.div_done)
                    begin
                        case (sel_reg)
                            psps_pkg::DIV_SEL_SIZE:
                            begin
                                sel_reg   <= psps_pkg::DIV_SEL_SQUARE;
                                state_reg <= S_DIV_START;
                            end
                            psps_pkg::DIV_SEL_SQUARE:
                            begin
                                sel_reg   <= stat.is_media ? psps_pkg::DIV_SEL_RATE
                                                           : psps_pkg::DIV_SEL_MEAN;
                                state_reg <= S_DIV_START;
                            end
                            psps_pkg::DIV_SEL_RATE:
                            begin
                                sel_reg   <= psps_pkg::DIV_SEL_MEAN;
                                state_reg <= S_DIV_START;
                            end
                            default:
                                state_reg <= S_OUT;
                        endcase
                    end
                S_OUT:
                    if (!(ovalid_reg && out_stall))
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/psps_datapath.sv =====
`timescale 1ns / 1ps
// Stream table in flip-flops plus one shared divider.
// Order: size mean, mean square, rate sample (media window close only),
// then rate mean, with the rate sample folded into the rate table first.
module psps_datapath #(
    parameter int STREAMS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  psps_pkg::psps_cmd_t  cmd,
    output psps_pkg::psps_stat_t stat,
    input  logic [15:0]          overhead_bytes,
    input  logic [15:0]          window_ms,
    input  logic [3:0]           stream_id,
    input  logic [31:0]          unit_number,
    input  logic                 is_media,
    input  logic [15:0]          packet_size,
    input  logic [31:0]          time_ms,
    output logic [3:0]           out_stream,
    output logic [47:0]          lost_count,
    output logic [31:0]          received_count,
    output logic [15:0]          size_min,
    output logic [15:0]          size_max,
    output logic [15:0]          size_mean,
    output logic [31:0]          size_mean_square,
    output logic                 window_closed,
    output logic [31:0]          rate_kbps,
    output logic [31:0]          rate_min,
    output logic [31:0]          rate_max,
    output logic [31:0]          rate_mean
);

    localparam int SW = (STREAMS > 1) ? $clog2(STREAMS) : 1;

    logic                clk_started_reg;
    logic [31:0]         start_time_reg;
    logic [STREAMS-1:0]  seen_reg;
    logic [31:0]         last_seq_reg   [STREAMS];
    logic [47:0]         lost_reg       [STREAMS];
    logic [31:0]         recv_reg       [STREAMS];
    logic [15:0]         smin_reg       [STREAMS];
    logic [15:0]         smax_reg       [STREAMS];
    logic [47:0]         ssum_reg       [STREAMS];
    logic [63:0]         ssq_reg        [STREAMS];
    logic [31:0]         wbytes_reg     [STREAMS];
    logic [31:0]         wstart_reg     [STREAMS];
    logic [31:0]         rsamp_reg      [STREAMS];
    logic [63:0]         rsum_reg       [STREAMS];
    logic [31:0]         rmin_reg       [STREAMS];
    logic [31:0]         rmax_reg       [STREAMS];

    logic [SW-1:0] sid_reg;
    logic [3:0]    sid4_reg;
    logic [31:0]   unit_reg, now_reg;
    logic          media_reg;
    logic [15:0]   size_reg;

    // per-item working values
    logic [31:0] elapsed_reg, wb_reg;
    logic        close_reg;
    logic [31:0] rate_reg;
    logic [15:0] mean_reg;
    logic [31:0] msq_reg, rmean_reg;

    logic [SW-1:0] s;
    assign s = sid_reg;

    // combinational update values
    logic [31:0] diff, rel, elapsed, win, t_now;
    logic [48:0] lsum;
    logic [47:0] lost_new;
    logic [48:0] ss_add;
    logic [64:0] sq_add;
    logic [31:0] sq;
    logic [32:0] wb_add;
    logic [31:0] wb_new;

    always_comb
    begin
        t_now   = clk_started_reg ? start_time_reg : now_reg;
        rel     = now_reg - t_now;
        elapsed = rel - wstart_reg[s];
        win     = (window_ms == 16'd0) ? 32'd1 : {16'd0, window_ms};
        diff    = unit_reg - last_seq_reg[s] - 32'd1;
        lsum    = {lost_reg[s][47], lost_reg[s]} + {{17{diff[31]}}, diff};
        if (lsum[48] != lsum[47])
            lost_new = lsum[48] ? psps_pkg::LOST_MIN : psps_pkg::LOST_MAX;
        else
            lost_new = lsum[47:0];
        sq     = {16'd0, size_reg} * {16'd0, size_reg};
        ss_add = {1'b0, ssum_reg[s]} + {33'd0, size_reg};
        sq_add = {1'b0, ssq_reg[s]} + {33'd0, sq};
        wb_add = {1'b0, wbytes_reg[s]} + {16'd0, size_reg} + {17'd0, overhead_bytes};
        wb_new = wb_add[32] ? 32'hFFFF_FFFF : wb_add[31:0];
    end

    // divider
    logic [63:0] dnum, dden, dquo;
    logic        ddone;

    always_comb
    begin
        case (cmd.div_sel)
            psps_pkg::DIV_SEL_SIZE:
            begin
                dnum = {16'd0, ssum_reg[s]};
                dden = {32'd0, recv_reg[s]};
            end
            psps_pkg::DIV_SEL_SQUARE:
            begin
                dnum = ssq_reg[s];
                dden = {32'd0, recv_reg[s]};
            end
            psps_pkg::DIV_SEL_RATE:
            begin
                dnum = {29'd0, wb_reg, 3'd0};
                dden = {32'd0, elapsed_reg};
            end
            default:
            begin
                dnum = rsum_reg[s];
                dden = {32'd0, rsamp_reg[s]};
            end
        endcase
    end

    psps_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (dnum),
        .den   (dden),
        .quo   (dquo),
        .done  (ddone)
    );

    assign stat.div_done = ddone;
    assign stat.is_media = media_reg && close_reg;

    logic [31:0] q32;
    assign q32 = (dquo[63:32] != 32'd0) ? 32'hFFFF_FFFF : dquo[31:0];

    logic [31:0] rt;
    logic [64:0] rs_add;
    assign rt     = q32;
    assign rs_add = {1'b0, rsum_reg[s]} + {33'd0, rt};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_started_reg <= 1'b0;
            start_time_reg  <= '0;
            seen_reg        <= '0;
            for (int i = 0; i < STREAMS; i++)
            begin
                last_seq_reg[i] <= '0;
                lost_reg[i]     <= '0;
                recv_reg[i]     <= '0;
                smin_reg[i]     <= 16'hFFFF;
                smax_reg[i]     <= '0;
                ssum_reg[i]     <= '0;
                ssq_reg[i]      <= '0;
                wbytes_reg[i]   <= '0;
                wstart_reg[i]   <= '0;
                rsamp_reg[i]    <= '0;
                rsum_reg[i]     <= '0;
                rmin_reg[i]     <= '1;
                rmax_reg[i]     <= '0;
            end
        end
        else
        begin
            if (cmd.update)
            begin
                clk_started_reg <= 1'b1;
                start_time_reg  <= t_now;
                seen_reg[s]     <= 1'b1;
                last_seq_reg[s] <= unit_reg;
                if (seen_reg[s] && unit_reg != last_seq_reg[s] + 32'd1)
                    lost_reg[s] <= lost_new;
                if (media_reg)
                begin
                    if (recv_reg[s] != 32'hFFFF_FFFF)
                        recv_reg[s] <= recv_reg[s] + 32'd1;
                    if (size_reg < smin_reg[s])
                        smin_reg[s] <= size_reg;
                    if (size_reg > smax_reg[s])
                        smax_reg[s] <= size_reg;
                    ssum_reg[s] <= (ss_add[48] || ss_add[47:0] == psps_pkg::SUM48_MAX)
                                   ? psps_pkg::SUM48_MAX : ss_add[47:0];
                    ssq_reg[s]  <= sq_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq_add[63:0];
                    if (elapsed >= win)
                    begin
                        wbytes_reg[s] <= '0;
                        wstart_reg[s] <= rel;
                    end
                    else
                        wbytes_reg[s] <= wb_new;
                end
            end
            if (cmd.div_store && cmd.div_sel == psps_pkg::DIV_SEL_RATE)
            begin
                if (rsamp_reg[s] != 32'hFFFF_FFFF)
                    rsamp_reg[s] <= rsamp_reg[s] + 32'd1;
                rsum_reg[s] <= rs_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : rs_add[63:0];
                if (rt < rmin_reg[s])
                    rmin_reg[s] <= rt;
                if (rt > rmax_reg[s])
                    rmax_reg[s] <= rt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            close_reg <= 1'b0;
        else if (cmd.load_item)
            close_reg <= 1'b0;
        else if (cmd.update)
            close_reg <= media_reg && (elapsed >= win);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            sid_reg   <= SW'(stream_id);
            sid4_reg  <= stream_id;
            unit_reg  <= unit_number;
            media_reg <= is_media;
            size_reg  <= packet_size;
            now_reg   <= time_ms;
            rate_reg  <= '0;
        end
        if (cmd.update)
        begin
            elapsed_reg <= elapsed;
            wb_reg      <= wb_new;
        end
        if (cmd.div_store)
        begin
            case (cmd.div_sel)
                psps_pkg::DIV_SEL_SIZE:
                    mean_reg <= (dquo > 64'd65535) ? 16'hFFFF : dquo[15:0];
                psps_pkg::DIV_SEL_SQUARE:
                    msq_reg <= (dquo > {32'd0, psps_pkg::MSQ_MAX}) ? psps_pkg::MSQ_MAX
                                                                   : dquo[31:0];
                psps_pkg::DIV_SEL_RATE:
                    rate_reg <= rt;
                default:
                    rmean_reg <= q32;
            endcase
        end
        if (cmd.out_load)
        begin
            out_stream       <= sid4_reg;
            lost_count       <= lost_reg[s];
            received_count   <= recv_reg[s];
            size_min         <= smin_reg[s];
            size_max         <= smax_reg[s];
            size_mean        <= mean_reg;
            size_mean_square <= msq_reg;
            window_closed    <= close_reg;
            rate_kbps        <= rate_reg;
            rate_min         <= rmin_reg[s];
            rate_max         <= rmax_reg[s];
            rate_mean        <= rmean_reg;
        end
    end

endmodule

// ===== hdl/per_stream_packet_statistics_top.sv =====
`timescale 1ns / 1ps
// Per-stream packet statistics.
// Input channel: one packet descriptor per item (stream_id, unit_number,
// is_media, packet_size, time_ms), accepted when in_valid is high and
// in_stall low. Output channel: one statistics item per packet, taken
// when out_valid is high and out_stall low. Packets whose stream_id is
// at or beyond STREAMS are dropped and give no item.
// Each item runs through an update step, then through three divisions for
// non-media packets and packets that do not close a window, four when a
// rate sample closes, and then an output step that raises out_valid.
// Without an output stall the next item can be taken in the same cycle
// as the result shows. The single shared 64-bit restoring divider (one
// bit a cycle) sets the pace; one item is in work at a time.
// Configuration: the user makes APB writes to overhead_bytes (0x0) and window_ms
// (0x4) only while idle; the block does not enforce it. Reset clears all
// stream statistics at once and sets window_ms to 100. A stalled result
// holds its payload; the next packet waits until the result register frees.
module per_stream_packet_statistics_top #(
    parameter int STREAMS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  stream_id,
    input  logic [31:0] unit_number,
    input  logic        is_media,
    input  logic [15:0] packet_size,
    input  logic [31:0] time_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  out_stream,
    output logic [47:0] lost_count,
    output logic [31:0] received_count,
    output logic [15:0] size_min,
    output logic [15:0] size_max,
    output logic [15:0] size_mean,
    output logic [31:0] size_mean_square,
    output logic        window_closed,
    output logic [31:0] rate_kbps,
    output logic [31:0] rate_min,
    output logic [31:0] rate_max,
    output logic [31:0] rate_mean
);

    logic [15:0] overhead_reg, window_reg;
    logic        in_ok;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == psps_pkg::ADDR_WINDOW) ? {16'd0, window_reg}
                                                        : {16'd0, overhead_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overhead_reg <= '0;
            window_reg   <= psps_pkg::WINDOW_RESET;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0)
        begin
            if (paddr[2] == psps_pkg::ADDR_OVERHEAD)
                overhead_reg <= pwdata[15:0];
            else
                window_reg <= pwdata[15:0];
        end
    end

    assign in_ok = ({28'd0, stream_id} < 32'(STREAMS));

    psps_pkg::psps_cmd_t  cmd;
    psps_pkg::psps_stat_t stat;

    psps_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ok     (in_ok),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    psps_datapath #(.STREAMS(STREAMS)) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .overhead_bytes   (overhead_reg),
        .window_ms        (window_reg),
        .stream_id        (stream_id),
        .unit_number      (unit_number),
        .is_media         (is_media),
        .packet_size      (packet_size),
        .time_ms          (time_ms),
        .out_stream       (out_stream),
        .lost_count       (lost_count),
        .received_count   (received_count),
        .size_min         (size_min),
        .size_max         (size_max),
        .size_mean        (size_mean),
        .size_mean_square (size_mean_square),
        .window_closed    (window_closed),
        .rate_kbps        (rate_kbps),
        .rate_min         (rate_min),
        .rate_max         (rate_max),
        .rate_mean        (rate_mean)
    );

endmodule
